FILE: design/sfd_pkg.sv
package sfd_pkg;

    localparam int unsigned BYTE_W = 8;

    localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'hAA;
    localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'h55;

    localparam int unsigned CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_FIRST  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_SECOND = 1'b1;

    typedef enum logic [2:0] {
        PH_HEAD1 = 3'd0,
        PH_HEAD2 = 3'd1,
        PH_LEN   = 3'd2,
        PH_SEQ   = 3'd3,
        PH_SYSID = 3'd4,
        PH_TYPE  = 3'd5,
        PH_DATA  = 3'd6,
        PH_CHECK = 3'd7
    } t_phase;

    typedef enum logic [1:0] {
        EV_FRAMING = 2'd0,
        EV_PAYLOAD = 2'd1,
        EV_GOOD    = 2'd2,
        EV_BAD     = 2'd3
    } t_event;

    typedef struct packed {
        t_event            event_res;
        logic [BYTE_W-1:0] payload_byte;
        logic [BYTE_W-1:0] payload_index;
        logic [BYTE_W-1:0] frame_type;
        logic [BYTE_W-1:0] frame_seq;
        logic [BYTE_W-1:0] frame_length;
    } t_result;

    typedef struct packed {
        logic [BYTE_W-1:0] header_first;
        logic [BYTE_W-1:0] header_second;
    } t_headers;

endpackage

FILE: design/sfd_cfg_regs.sv
module sfd_cfg_regs
    import sfd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]      i_cfg_data,
    output t_headers               o_headers
);

    t_headers r_headers;

    assign o_cfg_ready = 1'b1;
    assign o_headers   = r_headers;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_headers.header_first  <= HEADER_FIRST_RST;
            r_headers.header_second <= HEADER_SECOND_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HEADER_FIRST:  r_headers.header_first  <= i_cfg_data;
                CFG_HEADER_SECOND: r_headers.header_second <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

FILE: design/sfd_parser.sv
module sfd_parser
    import sfd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [BYTE_W-1:0] i_byte,
    input  t_headers          i_headers,
    output t_result           o_result
);

    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_sum, n_sum;
    logic [BYTE_W-1:0] r_len, n_len;
    logic [BYTE_W-1:0] r_count, n_count;
    logic [BYTE_W-1:0] r_seq, n_seq;
    logic [BYTE_W-1:0] r_type, n_type;
    logic [BYTE_W-1:0] count_inc;

    assign count_inc = r_count + 8'd1;

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_HEAD1: if (i_byte == i_headers.header_first)  n_phase = PH_HEAD2;
            PH_HEAD2: n_phase = (i_byte == i_headers.header_second) ? PH_LEN : PH_HEAD1;
            PH_LEN:   n_phase = PH_SEQ;
            PH_SEQ:   n_phase = PH_SYSID;
            PH_SYSID: if (i_byte != '0) n_phase = PH_TYPE;
            PH_TYPE:  n_phase = (r_len == '0) ? PH_CHECK : PH_DATA;
            PH_DATA:  if (count_inc >= r_len) n_phase = PH_CHECK;
            PH_CHECK: n_phase = PH_HEAD1;
            default:  n_phase = PH_HEAD1;
        endcase
    end

    // datapath and result
    always_comb begin
        n_sum   = r_sum;
        n_len   = r_len;
        n_count = r_count;
        n_seq   = r_seq;
        n_type  = r_type;
        o_result.event_res     = EV_FRAMING;
        o_result.payload_byte  = '0;
        o_result.payload_index = '0;
        unique case (r_phase)
            PH_HEAD1: if (i_byte == i_headers.header_first) n_sum = i_byte;
            PH_HEAD2: if (i_byte == i_headers.header_second) n_sum = r_sum + i_byte;
            PH_LEN: begin
                n_len   = i_byte;
                n_sum   = r_sum + i_byte;
                n_count = '0;
            end
            PH_SEQ: begin
                n_seq   = i_byte;
                n_sum   = r_sum + i_byte;
                n_count = '0;
            end
            PH_SYSID: begin
                // zero system id keeps the phase but still goes into the sum
                n_sum   = r_sum + i_byte;
                n_count = '0;
            end
            PH_TYPE: begin
                n_type  = i_byte;
                n_sum   = r_sum + i_byte;
                n_count = '0;
            end
            PH_DATA: begin
                o_result.event_res     = EV_PAYLOAD;
                o_result.payload_byte  = i_byte;
                o_result.payload_index = r_count;
                n_sum   = r_sum + i_byte;
                n_count = count_inc;
            end
            PH_CHECK: o_result.event_res = (r_sum == i_byte) ? EV_GOOD : EV_BAD;
            default: ;
        endcase
        o_result.frame_type   = n_type;
        o_result.frame_seq    = n_seq;
        o_result.frame_length = n_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEAD1;
            r_sum   <= '0;
            r_len   <= '0;
            r_count <= '0;
            r_seq   <= '0;
            r_type  <= '0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_sum   <= n_sum;
            r_len   <= n_len;
            r_count <= n_count;
            r_seq   <= n_seq;
            r_type  <= n_type;
        end
    end

endmodule

FILE: design/serial_frame_deframer_unit.sv
// A byte taken into the input register passes through the parser into the output
// register.
// Throughput: 1 byte per cycle; input register, parser state update and result
// register advance together whenever the result register is empty or taken.
// Reset (i_rst_n low, synchronous): parser hunts for the first header byte, sum,
// length, count, sequence and type clear, headers return to 0xAA / 0x55.
module serial_frame_deframer_unit
    import sfd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [BYTE_W-1:0]      i_data_byte,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [1:0]             o_event_res,
    output logic [BYTE_W-1:0]      o_payload_byte,
    output logic [BYTE_W-1:0]      o_payload_index,
    output logic [BYTE_W-1:0]      o_frame_type,
    output logic [BYTE_W-1:0]      o_frame_seq,
    output logic [BYTE_W-1:0]      o_frame_length,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]      i_cfg_data
);

    logic              advance;
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    t_result           r_out;
    t_result           result;
    t_headers          headers;

    // whole pipe holds while a finished result is not taken
    assign advance    = !(r_out_valid && i_out_stall);
    assign o_in_stall = !advance;

    sfd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_headers   (headers)
    );

    sfd_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (advance && r_in_valid),
        .i_byte    (r_in_byte),
        .i_headers (headers),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_in_valid  <= i_in_valid;
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_in_byte <= i_data_byte;
            if (r_in_valid) begin
                r_out <= result;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_event_res     = r_out.event_res;
    assign o_payload_byte  = r_out.payload_byte;
    assign o_payload_index = r_out.payload_index;
    assign o_frame_type    = r_out.frame_type;
    assign o_frame_seq     = r_out.frame_seq;
    assign o_frame_length  = r_out.frame_length;

endmodule

FILE: test/sfd_frame_checker.sv
`timescale 1ns / 1ps

module sfd_frame_checker
    import sfd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_stall,
    input  logic [BYTE_W-1:0]      i_data_byte,
    input  logic                   i_out_valid,
    input  logic                   i_out_stall,
    input  logic [1:0]             i_event_res,
    input  logic [BYTE_W-1:0]      i_payload_byte,
    input  logic [BYTE_W-1:0]      i_payload_index,
    input  logic [BYTE_W-1:0]      i_frame_type,
    input  logic [BYTE_W-1:0]      i_frame_seq,
    input  logic [BYTE_W-1:0]      i_frame_length,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]      i_cfg_data,
    output int                     o_fail_count,
    output int                     o_pending
);

    t_headers          headers;
    t_phase            phase;
    logic [BYTE_W-1:0] run_sum;
    logic [BYTE_W-1:0] frame_len;
    logic [BYTE_W-1:0] rx_count;
    logic [BYTE_W-1:0] seq_byte;
    logic [BYTE_W-1:0] type_byte;
    t_result           frame_events[$];
    t_result           want;

    // Advances the parser copy by one byte and returns the event it produces.
    function automatic t_result parse_byte(input logic [BYTE_W-1:0] b);
        t_result r;
        r = '0;
        r.event_res = EV_FRAMING;
        case (phase)
            PH_HEAD1: begin
                if (b == headers.header_first) begin
                    run_sum = b;
                    phase   = PH_HEAD2;
                end
            end
            PH_HEAD2: begin
                // a wrong second byte is not retried as a first header byte
                if (b == headers.header_second) begin
                    run_sum = run_sum + b;
                    phase   = PH_LEN;
                end else begin
                    phase = PH_HEAD1;
                end
            end
            PH_LEN: begin
                frame_len = b;
                run_sum   = run_sum + b;
                rx_count  = '0;
                phase     = PH_SEQ;
            end
            PH_SEQ: begin
                seq_byte = b;
                run_sum  = run_sum + b;
                rx_count = '0;
                phase    = PH_SYSID;
            end
            PH_SYSID: begin
                // zero id keeps the parser here, byte still summed
                run_sum  = run_sum + b;
                rx_count = '0;
                if (b != '0) begin
                    phase = PH_TYPE;
                end
            end
            PH_TYPE: begin
                type_byte = b;
                run_sum   = run_sum + b;
                rx_count  = '0;
                phase     = (frame_len == '0) ? PH_CHECK : PH_DATA;
            end
            PH_DATA: begin
                r.event_res     = EV_PAYLOAD;
                r.payload_byte  = b;
                r.payload_index = rx_count;
                run_sum         = run_sum + b;
                rx_count        = rx_count + 1'b1;
                if (rx_count >= frame_len) begin
                    phase = PH_CHECK;
                end
            end
            default: begin
                r.event_res = (run_sum == b) ? EV_GOOD : EV_BAD;
                phase       = PH_HEAD1;
            end
        endcase
        r.frame_type   = type_byte;
        r.frame_seq    = seq_byte;
        r.frame_length = frame_len;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [BYTE_W-1:0] exp_v,
                                 input logic [BYTE_W-1:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            headers.header_first  = HEADER_FIRST_RST;
            headers.header_second = HEADER_SECOND_RST;
            phase     = PH_HEAD1;
            run_sum   = '0;
            frame_len = '0;
            rx_count  = '0;
            seq_byte  = '0;
            type_byte = '0;
            frame_events.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_HEADER_FIRST) begin
                    headers.header_first = i_cfg_data;
                end else begin
                    headers.header_second = i_cfg_data;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                frame_events.push_back(parse_byte(i_data_byte));
            end
            if (i_out_valid && !i_out_stall) begin
                if (frame_events.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual event %0d",
                             $time, i_event_res);
                    o_fail_count++;
                end else begin
                    want = frame_events.pop_front();
                    compare_field("event_res", BYTE_W'(want.event_res),
                                  BYTE_W'(i_event_res));
                    compare_field("payload_byte", want.payload_byte, i_payload_byte);
                    compare_field("payload_index", want.payload_index, i_payload_index);
                    compare_field("frame_type", want.frame_type, i_frame_type);
                    compare_field("frame_seq", want.frame_seq, i_frame_seq);
                    compare_field("frame_length", want.frame_length, i_frame_length);
                end
            end
        end
        o_pending = frame_events.size();
    end

endmodule

FILE: test/serial_frame_deframer_unit_test.sv
`timescale 1ns / 1ps

module serial_frame_deframer_unit_test;
    import sfd_pkg::*;

    localparam int FRAME_ITEMS = 800;
    localparam int PHASES      = 6;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_TOGGLE
    } t_stall_mode;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_in_valid  = 1'b0;
    logic [BYTE_W-1:0]      i_data_byte = '0;
    logic                   i_out_stall = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [BYTE_W-1:0]      i_cfg_data  = '0;

    logic              o_in_stall;
    logic              o_out_valid;
    logic [1:0]        o_event_res;
    logic [BYTE_W-1:0] o_payload_byte;
    logic [BYTE_W-1:0] o_payload_index;
    logic [BYTE_W-1:0] o_frame_type;
    logic [BYTE_W-1:0] o_frame_seq;
    logic [BYTE_W-1:0] o_frame_length;
    logic              o_cfg_ready;

    int fail_count;
    int bytes_pending;

    int          burst_left  = 0;
    int          frame_bytes = 0;
    int          stall_left  = 0;
    t_stall_mode stall_mode  = STALL_NONE;
    t_headers    sync;

    serial_frame_deframer_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_event_res     (o_event_res),
        .o_payload_byte  (o_payload_byte),
        .o_payload_index (o_payload_index),
        .o_frame_type    (o_frame_type),
        .o_frame_seq     (o_frame_seq),
        .o_frame_length  (o_frame_length),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    sfd_frame_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_event_res     (o_event_res),
        .i_payload_byte  (o_payload_byte),
        .i_payload_index (o_payload_index),
        .i_frame_type    (o_frame_type),
        .i_frame_seq     (o_frame_seq),
        .i_frame_length  (o_frame_length),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (bytes_pending)
    );

    always #5 i_clk = ~i_clk;

    // receiver backpressure: a randomly chosen stall pattern, redrawn when its run ends
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            stall_left = $urandom_range(16, 128);
        end
        stall_left--;
        case (stall_mode)
            STALL_NONE:  i_out_stall <= 1'b0;
            STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
            default:     i_out_stall <= ~i_out_stall;
        endcase
    end

    // Sender works in bursts; valid stays high between transactions of a burst.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        burst_left--;
        frame_bytes++;
    endtask

    task automatic send_frame(input int len, input logic [BYTE_W-1:0] seq,
                              input logic [BYTE_W-1:0] sys_id, input logic [BYTE_W-1:0] kind,
                              input int zero_ids, input bit corrupt);
        logic [BYTE_W-1:0] acc;
        logic [BYTE_W-1:0] b;
        acc = sync.header_first + sync.header_second + BYTE_W'(len) + seq + sys_id + kind;
        send_byte(sync.header_first);
        send_byte(sync.header_second);
        send_byte(BYTE_W'(len));
        send_byte(seq);
        repeat (zero_ids) send_byte('0);
        send_byte(sys_id);
        send_byte(kind);
        for (int i = 0; i < len; i++) begin
            b = BYTE_W'($urandom);
            acc += b;
            send_byte(b);
        end
        if (corrupt) begin
            acc += BYTE_W'($urandom_range(1, 255));
        end
        send_byte(acc);
    endtask

    // wait until every byte has produced its result, then let the pipe settle
    task automatic drain();
        i_in_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (bytes_pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_headers(input logic [BYTE_W-1:0] first, input logic [BYTE_W-1:0] second);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_HEADER_FIRST;
        i_cfg_data  <= first;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_index <= CFG_HEADER_SECOND;
        i_cfg_data  <= second;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sync.header_first  = first;
        sync.header_second = second;
    endtask

    initial begin
        int                r;
        int                len;
        logic [BYTE_W-1:0] wrong;

        sync.header_first  = HEADER_FIRST_RST;
        sync.header_second = HEADER_SECOND_RST;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: idle bytes, a bad second header, zero length with zero ids,
        // and a short frame with a corrupted checksum
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(HEADER_FIRST_RST);
        send_byte(HEADER_FIRST_RST);
        send_byte(HEADER_SECOND_RST);
        send_frame(0, 8'hFF, 8'h01, 8'h00, 2, 1'b0);
        send_frame(2, 8'h00, 8'h80, 8'hFF, 0, 1'b1);

        for (int p = 0; p < PHASES; p++) begin
            drain();
            case (p)
                0:       write_headers(HEADER_FIRST_RST, HEADER_SECOND_RST);
                1:       write_headers(8'h00, 8'h00);
                2:       write_headers(8'hFF, 8'hFF);
                3:       write_headers(8'h00, 8'hFF);
                default: write_headers(BYTE_W'($urandom), BYTE_W'($urandom));
            endcase
            if (p == 0) begin
                send_frame(255, BYTE_W'($urandom), BYTE_W'($urandom_range(1, 255)),
                           BYTE_W'($urandom), 0, 1'b0);
            end
            while (frame_bytes < (p + 1) * FRAME_ITEMS / PHASES) begin
                r = $urandom_range(0, 9);
                if (r == 0) begin
                    repeat ($urandom_range(1, 6)) send_byte(BYTE_W'($urandom));
                end else if (r == 1) begin
                    wrong = sync.header_second ^ 8'($urandom_range(1, 255));
                    send_byte(sync.header_first);
                    send_byte(wrong);
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 3) begin
                        len = 255;
                    end else if (r < 15) begin
                        len = $urandom_range(9, 40);
                    end else begin
                        len = $urandom_range(0, 8);
                    end
                    send_frame(len, BYTE_W'($urandom), BYTE_W'($urandom_range(1, 255)),
                               BYTE_W'($urandom),
                               ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0,
                               $urandom_range(0, 4) == 0);
                end
            end
        end

        drain();
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: sim.f
design/sfd_pkg.sv
design/sfd_cfg_regs.sv
design/sfd_parser.sv
design/serial_frame_deframer_unit.sv
test/sfd_frame_checker.sv
test/serial_frame_deframer_unit_test.sv
